@@ src/wrr_pkg.sv @@
// ----------------------------------------------------------------------------
// wrr_pkg: shared types and constants
// Field widths, request codes and sequencer states of the weighted
// round-robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package wrr_pkg;

   localparam int TYPE_BITS  = 2;
   localparam int INDEX_BITS = 6;
   localparam int VALUE_BITS = 15;
   localparam int MASK_BITS  = 64;
   localparam int COUNT_BITS = 7;

   localparam logic [TYPE_BITS-1:0] REQ_SCHEDULE = 2'd0;
   localparam logic [TYPE_BITS-1:0] REQ_WRITE    = 2'd1;
   localparam logic [TYPE_BITS-1:0] REQ_UPDATE   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_CHECK,
      ST_UPD_RD,
      ST_UPD_USE,
      ST_UPD_GCD,
      ST_OUT
   } wrr_state_type;

endpackage

`default_nettype wire

@@ src/wrr_ifs.sv @@
// ----------------------------------------------------------------------------
// wrr_ifs: channel interfaces
// Request, response and register-write channels, each valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrr_req_if;
   import wrr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [TYPE_BITS-1:0]  req_type;
   logic [INDEX_BITS-1:0] dest_index;
   logic [VALUE_BITS-1:0] weight_value;
   logic [MASK_BITS-1:0]  avail_mask;
   modport source (output valid, req_type, dest_index, weight_value, avail_mask,
                   input ready);
   modport sink   (input valid, req_type, dest_index, weight_value, avail_mask,
                   output ready);
endinterface

interface wrr_rsp_if;
   import wrr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [INDEX_BITS-1:0] chosen_index;
   modport source (output valid, found, chosen_index, input ready);
   modport sink   (input valid, found, chosen_index, output ready);
endinterface

interface wrr_csr_if;
   import wrr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] dest_count;
   modport source (output valid, dest_count, input ready);
   modport sink   (input valid, dest_count, output ready);
endinterface

`default_nettype wire

@@ src/wrr_weight_ram.sv @@
// ----------------------------------------------------------------------------
// wrr_weight_ram: weight table
// One write port, one registered read port; per-entry valid bits make
// never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wrr_weight_ram #(
   parameter int DEPTH = 64,
   parameter int DW    = 15,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DW-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= ((rd_addr < DEPTH) && valid_ff[rd_addr]) ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/wrr_gcd_unit.sv @@
// ----------------------------------------------------------------------------
// wrr_gcd_unit: iterative gcd
// Binary gcd, one shift or one subtract per cycle; both operands nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module wrr_gcd_unit #(
   parameter int W = 15
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic              done,
   output logic      [W-1:0] result
);

   localparam int KW = $clog2(W + 1);

   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [KW-1:0] k_ff, k_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W-1:0]  result_ff, result_in;

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      k_in      = k_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         a_in    = a;
         b_in    = b;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ((a_ff == '0) || (b_ff == '0)) begin
            // one side is zero, the other holds the odd part
            result_in = (a_ff | b_ff) << k_ff;
            busy_in   = 1'b0;
            done_in   = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

@@ src/weighted_round_robin_scheduler.sv @@
// ----------------------------------------------------------------------------
// weighted_round_robin_scheduler: weighted round-robin destination picker
// Weight table, scan sequencer and a gcd unit used by updates.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  - one beat per item: schedule (uses avail_mask), write one weight
//              (dest_index, weight_value) or update (recompute max and gcd).
//   rsp_bus  - exactly one beat per item: found and chosen_index; both zero
//              for writes, updates, unknown codes and a failed schedule.
//   csr_bus  - writes dest_count; always ready; write only while idle.
// Sequence per item from the accept cycle on:
//   Write or unknown item: ST_OUT, which loads the response register.
//   Schedule: ST_STEP, then ST_CHECK (registered table read and compare), per
//   destination visited, then ST_OUT; an exit at a wrap skips the compare.
//   Walks may wrap the list several times as the current weight drops by the gcd.
//   Update: ST_UPD_RD and ST_UPD_USE per entry, plus a gcd unit run in
//   ST_UPD_GCD for each positive weight after the first, then ST_OUT.
//   req_bus.ready is high only when the sequencer is idle.
// Reset: weights read as zero, dest_count 0, position at head, current weight
//   0, max 0, gcd 1. No clearing pass.
// Stall: a response waits in the output register while the next item is
//   taken and worked; that item's result then waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_round_robin_scheduler #(
   parameter int MAX_DESTS   = 64,
   parameter int WEIGHT_BITS = 15
) (
   input  wire logic  clock,
   input  wire logic  reset,
   wrr_req_if.sink    req_bus,
   wrr_rsp_if.source  rsp_bus,
   wrr_csr_if.sink    csr_bus
);

   import wrr_pkg::*;

   localparam int AW = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;  // table address
   localparam int PW = $clog2(MAX_DESTS + 1);                      // 0..MAX_DESTS
   localparam int CW = WEIGHT_BITS + 2;                            // signed weight

   // state
   wrr_state_type           state_ff, state_in;
   logic [COUNT_BITS-1:0]   dest_count_ff, dest_count_in;
   logic [PW-1:0]           position_ff, position_in;
   logic signed [CW-1:0]    cw_ff, cw_in;
   logic [WEIGHT_BITS-1:0]  max_ff, max_in;
   logic [WEIGHT_BITS-1:0]  gcd_ff, gcd_in;

   // per-item working registers
   logic [MAX_DESTS-1:0]    mask_ff, mask_in;
   logic [PW-1:0]           start_ff, start_in;
   logic                    reload_ff, reload_in;
   logic [PW-1:0]           upd_idx_ff, upd_idx_in;
   logic [WEIGHT_BITS-1:0]  mw_ff, mw_in;
   logic [WEIGHT_BITS-1:0]  g_ff, g_in;
   logic                    res_found_ff, res_found_in;
   logic [INDEX_BITS-1:0]   res_index_ff, res_index_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [INDEX_BITS-1:0]   rsp_index_ff, rsp_index_in;

   // table and gcd unit hookup
   logic                    wr_en;
   logic [AW-1:0]           rd_addr;
   logic [WEIGHT_BITS-1:0]  rd_data;
   logic                    gcd_start;
   logic                    gcd_done;
   logic [WEIGHT_BITS-1:0]  gcd_result;

   logic                    req_accept;
   logic [COUNT_BITS-1:0]   cnt_clamp;
   logic [PW-1:0]           list_len;
   logic [PW-1:0]           pos_clamp;
   logic signed [CW-1:0]    di_s;
   logic signed [CW-1:0]    max_s;
   logic signed [CW-1:0]    mw_s;
   logic signed [CW-1:0]    weight_s;
   logic signed [CW-1:0]    cw_sub;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // list head: dest_count capped at the table depth
   assign cnt_clamp = (dest_count_ff > COUNT_BITS'(MAX_DESTS)) ?
                      COUNT_BITS'(MAX_DESTS) : dest_count_ff;
   assign list_len  = PW'(cnt_clamp);
   assign pos_clamp = (position_ff > list_len) ? list_len : position_ff;

   assign di_s     = signed'(CW'(gcd_ff));
   assign max_s    = signed'(CW'(max_ff));
   assign mw_s     = signed'(CW'(mw_ff));
   assign weight_s = signed'(CW'(rd_data));
   assign cw_sub   = cw_ff - di_s;

   assign wr_en = req_accept && (req_bus.req_type == REQ_WRITE) &&
                  ({1'b0, req_bus.dest_index} < (INDEX_BITS + 1)'(MAX_DESTS));

   wrr_weight_ram #(
      .DEPTH (MAX_DESTS),
      .DW    (WEIGHT_BITS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_bus.dest_index)),
      .wr_data (WEIGHT_BITS'(req_bus.weight_value)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wrr_gcd_unit #(
      .W (WEIGHT_BITS)
   ) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .a      (g_ff),
      .b      (rd_data),
      .done   (gcd_done),
      .result (gcd_result)
   );

   always_comb begin
      state_in      = state_ff;
      dest_count_in = dest_count_ff;
      position_in   = position_ff;
      cw_in         = cw_ff;
      max_in        = max_ff;
      gcd_in        = gcd_ff;
      mask_in       = mask_ff;
      start_in      = start_ff;
      reload_in     = reload_ff;
      upd_idx_in    = upd_idx_ff;
      mw_in         = mw_ff;
      g_in          = g_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rd_addr       = AW'(upd_idx_ff);
      gcd_start     = 1'b0;

      if (csr_bus.valid) begin
         dest_count_in = csr_bus.dest_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_found_in = 1'b0;
               res_index_in = '0;
               case (req_bus.req_type)
                  REQ_SCHEDULE: begin
                     position_in = pos_clamp;   // stale position acts as head
                     start_in    = pos_clamp;
                     reload_in   = 1'b0;
                     mask_in     = MAX_DESTS'(req_bus.avail_mask);
                     state_in    = ST_STEP;
                  end
                  REQ_UPDATE: begin
                     upd_idx_in = '0;
                     mw_in      = '0;
                     g_in       = '0;
                     state_in   = ST_UPD_RD;
                  end
                  default: begin
                     // write lands in the table on this edge; unknown is a no-op
                     state_in = ST_OUT;
                  end
               endcase
            end
         end

         // advance one entry; wrap at the head lowers the current weight by the gcd or reloads it to max
         ST_STEP: begin
            state_in = ST_CHECK;
            if (position_ff == list_len) begin
               if (list_len == '0) begin
                  state_in = ST_OUT;
               end else begin
                  position_in = '0;
                  if (cw_sub[CW-1] || (cw_sub == '0)) begin
                     cw_in = max_s;
                     if (max_ff == '0) begin
                        position_in = list_len;   // all weights zero
                        state_in    = ST_OUT;
                     end else if (reload_ff) begin
                        state_in = ST_OUT;        // second reload: hopeless walk
                     end else begin
                        reload_in = 1'b1;
                     end
                  end else begin
                     cw_in = cw_sub;
                  end
               end
            end else begin
               position_in = position_ff + 1'b1;
            end
            rd_addr = AW'(position_in);
         end

         // table data for the entry now valid
         ST_CHECK: begin
            if ((position_ff != list_len) && mask_ff[AW'(position_ff)] &&
                (weight_s >= cw_ff)) begin
               res_found_in = 1'b1;
               res_index_in = INDEX_BITS'(position_ff);
               state_in     = ST_OUT;
            end else if ((position_ff == start_ff) && (cw_ff == di_s)) begin
               state_in = ST_OUT;   // full pass at the lowest weight
            end else begin
               state_in = ST_STEP;
            end
         end

         ST_UPD_RD: begin
            if (upd_idx_ff == list_len) begin
               position_in = list_len;
               max_in      = mw_ff;
               gcd_in      = (g_ff == '0) ? WEIGHT_BITS'(1) : g_ff;
               if (cw_ff > mw_s) begin
                  cw_in = '0;
               end
               state_in = ST_OUT;
            end else begin
               state_in = ST_UPD_USE;
            end
         end

         ST_UPD_USE: begin
            if (rd_data > mw_ff) begin
               mw_in = rd_data;
            end
            if (rd_data == '0) begin
               upd_idx_in = upd_idx_ff + 1'b1;
               state_in   = ST_UPD_RD;
            end else if (g_ff == '0) begin
               g_in       = rd_data;
               upd_idx_in = upd_idx_ff + 1'b1;
               state_in   = ST_UPD_RD;
            end else begin
               gcd_start = 1'b1;
               state_in  = ST_UPD_GCD;
            end
         end

         ST_UPD_GCD: begin
            if (gcd_done) begin
               g_in       = gcd_result;
               upd_idx_in = upd_idx_ff + 1'b1;
               state_in   = ST_UPD_RD;
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_index_in = res_index_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dest_count_ff <= '0;
         position_ff   <= '0;
         cw_ff         <= '0;
         max_ff        <= '0;
         gcd_ff        <= WEIGHT_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dest_count_ff <= dest_count_in;
         position_ff   <= position_in;
         cw_ff         <= cw_in;
         max_ff        <= max_in;
         gcd_ff        <= gcd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      start_ff     <= start_in;
      reload_ff    <= reload_in;
      upd_idx_ff   <= upd_idx_in;
      mw_ff        <= mw_in;
      g_ff         <= g_in;
      res_found_ff <= res_found_in;
      res_index_ff <= res_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.chosen_index = rsp_index_ff;

endmodule

`default_nettype wire
